// ===== src/grd_pkg.sv =====
// ----------------------------------------------------------------------------
// grd_pkg
// Shared constants, coefficient tables and fixed-point helpers for the gamma
// ramp generator.
// ----------------------------------------------------------------------------
package grd_pkg;

  localparam int INDEX_BITS   = 16;
  localparam int LOG_F        = 20;
  localparam int FIX_W        = 36;
  localparam int MAG_W        = 30;
  localparam int CT_W         = 14;
  localparam int BRIGHT_W     = 17;
  localparam int LEN_W        = 17;
  localparam int CFG_W        = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_W        = 32;
  localparam int X_W          = 28;
  localparam int MANT_W       = LOG_F + 1;
  localparam int LEVEL_W      = 8;
  localparam int WORD_W       = 16;
  localparam int NUM_FITS     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TEMP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH = 2'd2;

  localparam logic [CT_W-1:0]     CT_RESET     = 14'd6500;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 17'd65536;
  localparam logic [LEN_W-1:0]    LEN_RESET    = 17'd256;

  localparam logic [CT_W-1:0] CT_SPLIT    = 14'd6500;
  localparam logic [CT_W-1:0] CT_BLUE_LOW = 14'd1900;

  // The temperature times 2^18 / 25 is taken as a reciprocal product, which is
  // exact for every 14-bit temperature.
  localparam int                   RECIP_T_W        = 33;
  localparam logic [RECIP_T_W-1:0] TEMP_RECIP       = 33'd5497558139;
  localparam int                   TEMP_RECIP_SHIFT = 19;

  localparam logic [16:0] RECIP_255  = 17'd65793;
  localparam logic [40:0] SAT_LIMIT  = 41'd16711680;
  localparam logic [7:0]  LEVEL_MAX  = 8'd255;

  localparam longint ONE_L   = 64'sd1 << LOG_F;
  localparam longint Billion = 64'sd1000000000;

  typedef logic [2:0][LEVEL_W-1:0] level_vec_t;

  typedef struct packed {
    logic       busy;
    level_vec_t levels;
  } grd_lvl_t;

  function automatic logic signed [FIX_W-1:0] q_coef(input logic neg, input longint ip,
                                                     input longint f9);
    longint mag;
    mag = ip * ONE_L + (f9 * ONE_L) / Billion;
    return neg ? FIX_W'(-mag) : FIX_W'(mag);
  endfunction

  // Fit sets: red, green below the split, green above the split, blue.
  localparam logic signed [FIX_W-1:0] COEF_A [NUM_FITS] = '{
    q_coef(1'b0, 351, 976905668), q_coef(1'b1, 155, 254855627),
    q_coef(1'b0, 325, 449412571), q_coef(1'b1, 254, 769351841)};
  localparam logic signed [FIX_W-1:0] COEF_B [NUM_FITS] = '{
    q_coef(1'b0, 0, 114206454), q_coef(1'b1, 0, 445969505),
    q_coef(1'b0, 0, 79434565),  q_coef(1'b0, 0, 827409606)};
  localparam logic signed [FIX_W-1:0] COEF_C [NUM_FITS] = '{
    q_coef(1'b1, 40, 253663093), q_coef(1'b0, 104, 492161994),
    q_coef(1'b1, 28, 85296351),  q_coef(1'b0, 115, 679944011)};
  localparam logic signed [FIX_W-1:0] LN2_Q = q_coef(1'b0, 0, 693147181);
  localparam logic [6:0] FIT_OFFSET [NUM_FITS] = '{7'd55, 7'd2, 7'd50, 7'd10};

  localparam logic [1:0] FIT_RED     = 2'd0;
  localparam logic [1:0] FIT_GREEN_L = 2'd1;
  localparam logic [1:0] FIT_GREEN_H = 2'd2;
  localparam logic [1:0] FIT_BLUE    = 2'd3;

  // Signed fixed-point product, magnitude truncated toward zero.
  function automatic logic signed [FIX_W-1:0] smul(input logic signed [FIX_W-1:0] a,
                                                   input logic signed [FIX_W-1:0] b);
    logic [FIX_W-1:0]     ua;
    logic [FIX_W-1:0]     ub;
    logic [2*MAG_W-1:0]   p;
    logic [FIX_W-1:0]     m;
    ua = a[FIX_W-1] ? FIX_W'(-a) : FIX_W'(a);
    ub = b[FIX_W-1] ? FIX_W'(-b) : FIX_W'(b);
    p  = ua[MAG_W-1:0] * ub[MAG_W-1:0];
    m  = FIX_W'(p >> LOG_F);
    return (a[FIX_W-1] ^ b[FIX_W-1]) ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== src/grd_level_seq.sv =====
// ----------------------------------------------------------------------------
// grd_level_seq
// Sequencer that derives the three 8-bit channel levels from the color
// temperature through the piecewise a + b*x + c*ln(x) fit.
// ----------------------------------------------------------------------------
module grd_level_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [grd_pkg::CT_W-1:0]  color_temp,
  output grd_pkg::grd_lvl_t         status
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_CHAN = 9'b000000100,
    S_NORM = 9'b000001000,
    S_SQR  = 9'b000010000,
    S_LOG  = 9'b000100000,
    S_T1   = 9'b001000000,
    S_T2   = 9'b010000000,
    S_SUM  = 9'b100000000
  } seq_state_t;

  seq_state_t                             state;
  logic [grd_pkg::X_W-1:0]                divw;
  logic [4:0]                             cnt;
  logic [1:0]                             chan;
  logic [1:0]                             fset;
  logic signed [grd_pkg::FIX_W-1:0]       xs;
  logic [grd_pkg::X_W-1:0]                xn;
  logic [4:0]                             sh;
  logic [grd_pkg::MANT_W-1:0]             m;
  logic [grd_pkg::LOG_F-1:0]              frac;
  logic signed [grd_pkg::FIX_W-1:0]       lnv;
  logic signed [grd_pkg::FIX_W-1:0]       t1;
  logic signed [grd_pkg::FIX_W-1:0]       t2;
  grd_pkg::level_vec_t                    levels;

  logic [grd_pkg::CT_W+grd_pkg::RECIP_T_W-1:0] tprod;
  logic                                   use_fit;
  logic [1:0]                             fit_sel;
  logic [grd_pkg::LEVEL_W-1:0]            const_lvl;
  logic signed [grd_pkg::FIX_W-1:0]       xd;
  logic [2*grd_pkg::MANT_W-1:0]           sq;
  logic [grd_pkg::MANT_W:0]               ms;
  logic signed [grd_pkg::FIX_W-1:0]       expo;
  logic signed [grd_pkg::FIX_W-1:0]       lg2;
  logic signed [grd_pkg::FIX_W-1:0]       sum;
  logic [grd_pkg::LEVEL_W-1:0]            sum_lvl;

  always_comb begin
    use_fit   = 1'b0;
    fit_sel   = grd_pkg::FIT_RED;
    const_lvl = '0;
    case (chan)
      2'd0: begin
        if (color_temp <= grd_pkg::CT_SPLIT) begin
          const_lvl = grd_pkg::LEVEL_MAX;
        end else begin
          use_fit = 1'b1;
          fit_sel = grd_pkg::FIT_RED;
        end
      end
      2'd1: begin
        use_fit = 1'b1;
        fit_sel = (color_temp <= grd_pkg::CT_SPLIT) ? grd_pkg::FIT_GREEN_L
                                                     : grd_pkg::FIT_GREEN_H;
      end
      2'd2: begin
        if (color_temp <= grd_pkg::CT_BLUE_LOW) begin
          const_lvl = '0;
        end else if (color_temp < grd_pkg::CT_SPLIT) begin
          use_fit = 1'b1;
          fit_sel = grd_pkg::FIT_BLUE;
        end else begin
          const_lvl = grd_pkg::LEVEL_MAX;
        end
      end
      default: const_lvl = '0;
    endcase
  end

  assign tprod = color_temp * grd_pkg::TEMP_RECIP;
  assign xd   = $signed({{(grd_pkg::FIX_W-grd_pkg::X_W){1'b0}}, divw})
              - $signed({{(grd_pkg::FIX_W-7-grd_pkg::LOG_F){1'b0}},
                         grd_pkg::FIT_OFFSET[fit_sel], {grd_pkg::LOG_F{1'b0}}});
  assign sq   = m * m;
  assign ms   = sq[grd_pkg::LOG_F +: grd_pkg::MANT_W+1];
  assign expo = grd_pkg::FIX_W'($signed(6'sd7 - $signed({1'b0, sh})));
  assign lg2  = (expo <<< grd_pkg::LOG_F)
              + $signed({{(grd_pkg::FIX_W-grd_pkg::LOG_F){1'b0}}, frac});
  assign sum  = grd_pkg::COEF_A[fset] + t1 + t2;

  always_comb begin
    if (sum < 0) begin
      sum_lvl = '0;
    end else if (sum >= $signed(grd_pkg::FIX_W'(255) <<< grd_pkg::LOG_F)) begin
      sum_lvl = grd_pkg::LEVEL_MAX;
    end else begin
      sum_lvl = sum[grd_pkg::LOG_F +: grd_pkg::LEVEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      chan  <= '0;
      cnt   <= '0;
    end else if (start) begin
      state <= S_LOAD;
    end else begin
      case (state)
        S_IDLE: begin
          state <= S_IDLE;
        end
        S_LOAD: begin
          divw  <= tprod[grd_pkg::TEMP_RECIP_SHIFT +: grd_pkg::X_W];
          chan  <= '0;
          state <= S_CHAN;
        end
        S_CHAN: begin
          if (use_fit && xd > 0) begin
            fset  <= fit_sel;
            xs    <= xd;
            xn    <= xd[grd_pkg::X_W-1:0];
            sh    <= '0;
            state <= S_NORM;
          end else begin
            levels[chan] <= use_fit ? '0 : const_lvl;
            if (chan == 2'd2) begin
              state <= S_IDLE;
            end else begin
              chan <= chan + 2'd1;
            end
          end
        end
        S_NORM: begin
          if (xn[grd_pkg::X_W-1]) begin
            m     <= xn[grd_pkg::X_W-1 -: grd_pkg::MANT_W];
            frac  <= '0;
            cnt   <= '0;
            state <= S_SQR;
          end else begin
            xn <= {xn[grd_pkg::X_W-2:0], 1'b0};
            sh <= sh + 5'd1;
          end
        end
        S_SQR: begin
          if (ms[grd_pkg::MANT_W]) begin
            m    <= ms[grd_pkg::MANT_W:1];
            frac <= {frac[grd_pkg::LOG_F-2:0], 1'b1};
          end else begin
            m    <= ms[grd_pkg::MANT_W-1:0];
            frac <= {frac[grd_pkg::LOG_F-2:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(grd_pkg::LOG_F-1)) begin
            state <= S_LOG;
          end
        end
        S_LOG: begin
          lnv   <= grd_pkg::smul(lg2, grd_pkg::LN2_Q);
          state <= S_T1;
        end
        S_T1: begin
          t1    <= grd_pkg::smul(grd_pkg::COEF_B[fset], xs);
          state <= S_T2;
        end
        S_T2: begin
          t2    <= grd_pkg::smul(grd_pkg::COEF_C[fset], lnv);
          state <= S_SUM;
        end
        S_SUM: begin
          levels[chan] <= sum_lvl;
          if (chan == 2'd2) begin
            state <= S_IDLE;
          end else begin
            chan  <= chan + 2'd1;
            state <= S_CHAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.busy   = (state != S_IDLE);
  assign status.levels = levels;

endmodule

// ===== src/grd_div_cell.sv =====
// ----------------------------------------------------------------------------
// grd_div_cell
// One restoring division step: shifts one dividend bit into the remainder
// and one quotient bit into the low end of the shared shift word.
// ----------------------------------------------------------------------------
module grd_div_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [grd_pkg::LEN_W-1:0]   in_rem,
  input  logic [grd_pkg::NUM_W-1:0]   in_nq,
  input  logic [grd_pkg::LEN_W-1:0]   divisor,
  output logic                        out_valid,
  output logic [grd_pkg::LEN_W-1:0]   out_rem,
  output logic [grd_pkg::NUM_W-1:0]   out_nq
);

  logic [grd_pkg::LEN_W:0] t;
  logic                    fits;

  assign t    = {in_rem, in_nq[grd_pkg::NUM_W-1]};
  assign fits = (t >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= fits ? grd_pkg::LEN_W'(t - {1'b0, divisor}) : t[grd_pkg::LEN_W-1:0];
      out_nq  <= {in_nq[grd_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

// ===== src/grd_scale.sv =====
// ----------------------------------------------------------------------------
// grd_scale
// Scales a ramp base by a channel level and the brightness, divides by
// 255 * 65536 and saturates to a 16-bit word.
// ----------------------------------------------------------------------------
module grd_scale (
  input  logic                          clk,
  input  logic                          en,
  input  logic [grd_pkg::NUM_W-1:0]     base,
  input  logic [grd_pkg::LEVEL_W-1:0]   level,
  input  logic [grd_pkg::BRIGHT_W-1:0]  brightness,
  output logic [grd_pkg::WORD_W-1:0]    word
);

  logic [39:0] p1;
  logic [56:0] p2;
  logic [40:0] q;
  logic [40:0] qm;
  logic [23:0] qc;
  logic [16:0] w0;
  logic        sat;
  logic [24:0] r;
  logic [16:0] w;

  assign q  = p2[56:16];
  assign qm = q[23:0] * grd_pkg::RECIP_255;

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= base * level;
      p2  <= p1 * brightness;
      sat <= (q >= grd_pkg::SAT_LIMIT);
      qc  <= q[23:0];
      w0  <= qm[40:24];
    end
  end

  assign r    = {1'b0, qc} - ({w0, 8'b0} - {8'b0, w0});
  assign w    = (r >= 25'd255) ? w0 + 17'd1 : w0;
  assign word = sat ? {grd_pkg::WORD_W{1'b1}} : w[grd_pkg::WORD_W-1:0];

endmodule

// ===== src/gamma_ramp_from_color_temp.sv =====
// ----------------------------------------------------------------------------
// gamma_ramp_from_color_temp
// Gives the red, green and blue gamma ramp words for each ramp index.
// ----------------------------------------------------------------------------
// The input channel carries a ramp index; each transfer yields one output
// transfer with the three ramp words, in order. Both channels use valid and
// stall. Configuration is written through cfg_we, cfg_index and cfg_data:
// index 0 is the color temperature, 1 the brightness, 2 the ramp length.
// Throughput is one item per cycle while in_stall is low. Between the input
// transfer and the output transfer an item passes through 32 divider cells
// producing one quotient bit each, one base register, three scaling stages
// and the output register.
// The channel levels depend only on the color temperature. After reset and
// after every write of the color temperature a sequencer recomputes them;
// in_stall stays high while it runs. A write of the other registers takes
// effect at once.
// When the receiver stalls, the output register holds its word and the
// pipeline keeps moving until its last stage holds an item; empty stages
// are squeezed out, then in_stall rises.
// ----------------------------------------------------------------------------
module gamma_ramp_from_color_temp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       ramp_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       red_value,
  output logic [15:0]                       green_value,
  output logic [15:0]                       blue_value,
  input  logic                              cfg_we,
  input  logic [grd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int NCELL = grd_pkg::NUM_W;

  logic [grd_pkg::CT_W-1:0]      color_temp;
  logic [grd_pkg::BRIGHT_W-1:0]  brightness;
  logic [grd_pkg::LEN_W-1:0]     ramp_length;
  logic                          start;
  grd_pkg::grd_lvl_t             lvl;
  logic                          en;
  logic                          accept;
  logic [grd_pkg::NUM_W-1:0]     num0;

  logic                          cv [NCELL+1];
  logic [grd_pkg::LEN_W-1:0]     crem [NCELL+1];
  logic [grd_pkg::NUM_W-1:0]     cnq [NCELL+1];

  logic [grd_pkg::NUM_W-1:0]     base;
  logic                          va;
  logic                          vb;
  logic                          vc;
  logic                          vd;
  logic [grd_pkg::WORD_W-1:0]    words [3];

  assign start = cfg_we && (cfg_index == grd_pkg::REG_COLOR_TEMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      color_temp  <= grd_pkg::CT_RESET;
      brightness  <= grd_pkg::BRIGHT_RESET;
      ramp_length <= grd_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        grd_pkg::REG_COLOR_TEMP:  color_temp  <= cfg_data[grd_pkg::CT_W-1:0];
        grd_pkg::REG_BRIGHTNESS:  brightness  <= cfg_data[grd_pkg::BRIGHT_W-1:0];
        grd_pkg::REG_RAMP_LENGTH: ramp_length <= cfg_data[grd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  grd_level_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .color_temp (color_temp),
    .status     (lvl)
  );

  assign en       = !(out_valid && out_stall && vd);
  assign in_stall = lvl.busy || start || !en;
  assign accept   = in_valid && !in_stall;

  assign num0 = ({{(grd_pkg::NUM_W-grd_pkg::INDEX_BITS){1'b0}},
                  ramp_index[grd_pkg::INDEX_BITS-1:0]} << 16)
              - {{(grd_pkg::NUM_W-grd_pkg::INDEX_BITS){1'b0}},
                 ramp_index[grd_pkg::INDEX_BITS-1:0]};

  assign cv[0]   = accept;
  assign crem[0] = '0;
  assign cnq[0]  = num0;

  for (genvar i = 0; i < NCELL; i++) begin : g_div
    grd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[i]),
      .in_rem    (crem[i]),
      .in_nq     (cnq[i]),
      .divisor   (ramp_length),
      .out_valid (cv[i+1]),
      .out_rem   (crem[i+1]),
      .out_nq    (cnq[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      va <= cv[NCELL];
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base <= (ramp_length == '0) ? '0 : cnq[NCELL];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_scale
    grd_scale u_scale (
      .clk        (clk),
      .en         (en),
      .base       (base),
      .level      (lvl.levels[c]),
      .brightness (brightness),
      .word       (words[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (vd && en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vd && en) begin
      red_value   <= words[0];
      green_value <= words[1];
      blue_value  <= words[2];
    end
  end

`ifndef ASSERT_OFF
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ramp_length == '0) |->
      (red_value == '0 && green_value == '0 && blue_value == '0))
    else $error("nonzero word with zero ramp length");

  a_zero_bright: assert property (@(posedge clk) disable iff (rst)
    (out_valid && brightness == '0) |->
      (red_value == '0 && green_value == '0 && blue_value == '0))
    else $error("nonzero word with zero brightness");

  a_red_full: assert property (@(posedge clk) disable iff (rst)
    (!lvl.busy && color_temp <= grd_pkg::CT_SPLIT) |-> lvl.levels[0] == grd_pkg::LEVEL_MAX)
    else $error("red level not full at or below split temperature");

  a_blue_off: assert property (@(posedge clk) disable iff (rst)
    (!lvl.busy && color_temp <= grd_pkg::CT_BLUE_LOW) |-> lvl.levels[2] == '0)
    else $error("blue level not zero at low temperature");

  a_hold_tail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && vd) |=> vd)
    else $error("pipeline tail lost while output stalled");
`endif

endmodule
